// ===== src/srtp_pkg.sv =====
package srtp_pkg;

    localparam int SALT_BYTES = 14;
    localparam int NUM_ROUNDS = 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] REG_KEY_HIGH  = 2'd0;
    localparam logic [1:0] REG_KEY_LOW   = 2'd1;
    localparam logic [1:0] REG_SALT_HIGH = 2'd2;
    localparam logic [1:0] REG_SALT_LOW  = 2'd3;

    typedef struct packed {
        logic [7:0]   data;
        logic         last;
        logic         new_block;
        logic [127:0] counter_block;
        logic [3:0]   position;
    } srtp_item_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        gf_mul = p;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] b;
        logic [7:0] e;
        r = 8'h01;
        b = x;
        e = 8'd254;
        for (int i = 0; i < 8; i++) begin
            if (e[i]) r = gf_mul(r, b);
            b = gf_mul(b, b);
        end
        sbox = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
               ^ {r[3:0], r[7:4]} ^ 8'h63;
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s);
        logic [127:0] o;
        for (int i = 0; i < 16; i++) o[i*8 +: 8] = sbox(s[i*8 +: 8]);
        sub_bytes = o;
    endfunction

    function automatic logic [7:0] st_byte(input logic [127:0] s, input int i);
        st_byte = s[127 - 8*i -: 8];
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127 - 8*(c*4+r) -: 8] = st_byte(s, ((c + r) % 4) * 4 + r);
        shift_rows = o;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = st_byte(s, c*4);
            a1 = st_byte(s, c*4+1);
            a2 = st_byte(s, c*4+2);
            a3 = st_byte(s, c*4+3);
            o[127 - 8*(c*4)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            o[127 - 8*(c*4+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            o[127 - 8*(c*4+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            o[127 - 8*(c*4+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        mix_columns = o;
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0] rcon);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_round_key = {w0, w1, w2, w3};
    endfunction

endpackage

// ===== src/srtp_aes_counter_payload_cipher_core.sv =====
// SRTP AES-128 counter-mode payload cipher.
// Input channel s_*: one payload byte per item with first/last packet marks;
// ssrc and packet_index are sampled on the first byte of a packet.
// Output channel m_*: one byte per item, data_in XOR keystream, with last_out.
// Configuration: cfg_we, cfg_index, cfg_data write key and salt registers.
// The front counts byte positions and forms the counter block; a four-entry
// queue feeds the back, which runs one AES round per cycle.
// Bytes within a keystream block pass through the queue and the output register
// and stream one per cycle while the receiver is ready. The first byte of each
// 16-byte block waits for the AES engine to compute its keystream block.
// When the receiver stalls, the output register holds and the queue fills;
// s_ready drops once four items are queued.
// Reset (aresetn low, synchronous) clears key and salt registers, counters and the queue.
module srtp_aes_counter_payload_cipher_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic [7:0]  s_data_in,
    input  logic        s_first_of_packet,
    input  logic        s_last_of_packet,
    input  logic [31:0] s_ssrc,
    input  logic [47:0] s_packet_index,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [7:0]  m_data_out,
    output logic        m_last_out,
    output logic        m_valid,
    input  logic        m_ready
);
    import srtp_pkg::*;

    srtp_item_t q_item;
    logic q_valid, q_ready;

    srtp_front u_front (
        .aclk, .aresetn, .cfg_index, .cfg_data, .cfg_we,
        .s_data_in, .s_first_of_packet, .s_last_of_packet, .s_ssrc, .s_packet_index,
        .s_valid, .s_ready, .q_item, .q_valid, .q_ready
    );

    srtp_back_wrap u_back (
        .aclk, .aresetn, .cfg_index, .cfg_data, .cfg_we,
        .q_item, .q_valid, .q_ready, .m_data_out, .m_last_out, .m_valid, .m_ready
    );

endmodule

// ===== src/srtp_front.sv =====
module srtp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                cfg_we,
    input  logic [7:0]          s_data_in,
    input  logic                s_first_of_packet,
    input  logic                s_last_of_packet,
    input  logic [31:0]         s_ssrc,
    input  logic [47:0]         s_packet_index,
    input  logic                s_valid,
    output logic                s_ready,
    output srtp_pkg::srtp_item_t q_item,
    output logic                q_valid,
    input  logic                q_ready
);
    import srtp_pkg::*;

    logic [47:0]  salt_high_reg;
    logic [63:0]  salt_low_reg;
    logic [111:0] prefix_reg;
    logic [15:0]  block_number_reg;
    logic [3:0]   byte_position_reg;
    logic [111:0] prefix_now;
    logic [15:0]  block_now;
    logic [3:0]   pos_now;
    logic [111:0] salt;
    logic         take;

    srtp_item_t mem [QUEUE_DEPTH];
    logic [QUEUE_AW:0] wptr_reg, rptr_reg;

    assign salt = {salt_high_reg, salt_low_reg};
    assign s_ready = (wptr_reg - rptr_reg) != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign take = s_valid && s_ready;

    always_comb begin
        if (s_first_of_packet) begin
            prefix_now = salt ^ {32'h0, s_ssrc, s_packet_index};
            block_now  = 16'h0;
            pos_now    = 4'h0;
        end else begin
            prefix_now = prefix_reg;
            block_now  = block_number_reg;
            pos_now    = byte_position_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            salt_high_reg     <= '0;
            salt_low_reg      <= '0;
            prefix_reg        <= '0;
            block_number_reg  <= '0;
            byte_position_reg <= '0;
            wptr_reg          <= '0;
        end else begin
            if (cfg_we && cfg_index == REG_SALT_HIGH) salt_high_reg <= cfg_data[47:0];
            if (cfg_we && cfg_index == REG_SALT_LOW)  salt_low_reg  <= cfg_data;
            if (take) begin
                prefix_reg        <= prefix_now;
                byte_position_reg <= pos_now + 4'd1;
                block_number_reg  <= (pos_now == 4'hf) ? block_now + 16'd1 : block_now;
                wptr_reg          <= wptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            mem[wptr_reg[QUEUE_AW-1:0]] <= '{data: s_data_in, last: s_last_of_packet,
                new_block: pos_now == 4'h0, counter_block: {prefix_now, block_now},
                position: pos_now};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rptr_reg <= '0;
        end else if (q_valid && q_ready) begin
            rptr_reg <= rptr_reg + 1'b1;
        end
    end

    assign q_valid = wptr_reg != rptr_reg;
    assign q_item  = mem[rptr_reg[QUEUE_AW-1:0]];

endmodule

// ===== src/srtp_back.sv =====
module srtp_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 cfg_we,
    input  srtp_pkg::srtp_item_t q_item,
    input  logic                 q_valid,
    output logic                 q_ready,
    output logic [7:0]           m_data_out,
    output logic                 m_last_out,
    output logic                 m_valid,
    input  logic                 m_ready
);
    import srtp_pkg::*;

    logic [127:0] key_reg;
    logic [127:0] state_reg, rkey_reg, ks_reg;
    logic [7:0]   rcon_reg;
    logic [3:0]   round_reg;
    logic         busy_reg;
    logic         hold_reg;
    logic [7:0]   data_out_reg;
    logic         last_out_reg, valid_reg;
    logic [127:0] round_out, rkey_next, sr;
    logic         out_free, need_key, fire;
    logic [7:0]   ks_byte;

    assign out_free = !valid_reg || m_ready;
    assign need_key = q_item.new_block;
    assign q_ready  = out_free && !busy_reg && (!need_key || hold_reg);
    assign fire     = q_valid && q_ready;
    assign ks_byte  = ks_reg[127 - 8*q_item.position -: 8];

    assign rkey_next = next_round_key(rkey_reg, rcon_reg);
    assign sr        = shift_rows(sub_bytes(state_reg));
    assign round_out = ((round_reg == 4'(NUM_ROUNDS)) ? sr : mix_columns(sr)) ^ rkey_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '0;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            round_reg <= '0;
        end else begin
            if (cfg_we && cfg_index == REG_KEY_HIGH) key_reg[127:64] <= cfg_data;
            if (cfg_we && cfg_index == REG_KEY_LOW)  key_reg[63:0]   <= cfg_data;
            if (!busy_reg && !hold_reg && q_valid && need_key) begin
                busy_reg  <= 1'b1;
                state_reg <= q_item.counter_block ^ key_reg;
                rkey_reg  <= key_reg;
                rcon_reg  <= 8'h01;
                round_reg <= 4'd1;
            end else if (busy_reg) begin
                state_reg <= round_out;
                rkey_reg  <= rkey_next;
                rcon_reg  <= xtime(rcon_reg);
                round_reg <= round_reg + 4'd1;
                if (round_reg == 4'(NUM_ROUNDS)) busy_reg <= 1'b0;
            end
            if (out_free) valid_reg <= fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 1'b0;
        end else if (busy_reg && round_reg == 4'(NUM_ROUNDS)) begin
            hold_reg <= 1'b1;
        end else if (fire) begin
            hold_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg && round_reg == 4'(NUM_ROUNDS)) ks_reg <= round_out;
        if (fire) begin
            data_out_reg <= q_item.data ^ ks_byte;
            last_out_reg <= q_item.last;
        end
    end

    assign m_data_out = data_out_reg;
    assign m_last_out = last_out_reg;
    assign m_valid    = valid_reg;

endmodule

// ===== src/srtp_back_wrap.sv =====
module srtp_back_wrap (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 cfg_we,
    input  srtp_pkg::srtp_item_t q_item,
    input  logic                 q_valid,
    output logic                 q_ready,
    output logic [7:0]           m_data_out,
    output logic                 m_last_out,
    output logic                 m_valid,
    input  logic                 m_ready
);
    import srtp_pkg::*;

    srtp_back u_core (
        .aclk, .aresetn, .cfg_index, .cfg_data, .cfg_we,
        .q_item, .q_valid, .q_ready,
        .m_data_out, .m_last_out, .m_valid, .m_ready
    );

endmodule

// ===== dv/srtp_aes_counter_payload_cipher_core_tb.sv =====
module srtp_aes_counter_payload_cipher_core_tb;
    import srtp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } cipher_byte_t;

    typedef struct {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [31:0] ssrc;
        logic [47:0] index;
        logic        typed;
        logic [7:0]  typed_out;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_KEY_HIGH;
    logic [63:0] cfg_data = '0;
    logic [7:0]  s_data_in = '0;
    logic        s_first_of_packet = 1'b0;
    logic        s_last_of_packet = 1'b0;
    logic [31:0] s_ssrc = '0;
    logic [47:0] s_packet_index = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  m_data_out;
    logic        m_last_out;
    logic        m_valid;
    logic        m_ready = 1'b0;

    srtp_aes_counter_payload_cipher_core u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_data_in         (s_data_in),
        .s_first_of_packet (s_first_of_packet),
        .s_last_of_packet  (s_last_of_packet),
        .s_ssrc            (s_ssrc),
        .s_packet_index    (s_packet_index),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .m_data_out        (m_data_out),
        .m_last_out        (m_last_out),
        .m_valid           (m_valid),
        .m_ready           (m_ready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // cipher state mirrored from the block
    logic [7:0]   sbox_tab [256];
    logic [127:0] sess_key = '0;
    logic [111:0] sess_salt = '0;
    logic [111:0] ctr_prefix = '0;
    logic [15:0]  blk_num = '0;
    logic [3:0]   byte_pos = '0;
    logic [127:0] ks_blk = '0;

    cipher_byte_t exp_bytes[$];
    int           errors = 0;
    int           cycles = 0;
    int           items_sent = 0;
    int           burst_left = 0;
    bit           tx_gaps = 1'b1;
    bit           rx_stalls = 1'b1;
    bit           rx_long = 1'b0;
    int           stall_left = 0;

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] inv;
        logic [7:0] sq;
        logic [7:0] ex;
        inv = 8'h01;
        sq = x;
        ex = 8'd254;
        for (int i = 0; i < 8; i++) begin
            if (ex[i]) inv = gmul(inv, sq);
            sq = gmul(sq, sq);
        end
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
               ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    function automatic logic [127:0] aes128(input logic [127:0] key, input logic [127:0] pt);
        logic [127:0] rk;
        logic [127:0] st;
        logic [127:0] sh;
        logic [7:0]   rc;
        logic [7:0]   a0, a1, a2, a3;
        logic [31:0]  w;
        rk = key;
        st = pt ^ rk;
        rc = 8'h01;
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int i = 0; i < 16; i++) st[127 - 8*i -: 8] = sbox_tab[st[127 - 8*i -: 8]];
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    sh[127 - 8*(c*4 + r) -: 8] = st[127 - 8*(((c + r) % 4)*4 + r) -: 8];
            st = sh;
            if (rnd < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[127 - 8*(c*4)     -: 8];
                    a1 = st[127 - 8*(c*4 + 1) -: 8];
                    a2 = st[127 - 8*(c*4 + 2) -: 8];
                    a3 = st[127 - 8*(c*4 + 3) -: 8];
                    st[127 - 8*(c*4)     -: 8] = gmul(a0, 2) ^ gmul(a1, 3) ^ a2 ^ a3;
                    st[127 - 8*(c*4 + 1) -: 8] = a0 ^ gmul(a1, 2) ^ gmul(a2, 3) ^ a3;
                    st[127 - 8*(c*4 + 2) -: 8] = a0 ^ a1 ^ gmul(a2, 2) ^ gmul(a3, 3);
                    st[127 - 8*(c*4 + 3) -: 8] = gmul(a0, 3) ^ a1 ^ a2 ^ gmul(a3, 2);
                end
            end
            w = {sbox_tab[rk[23:16]] ^ rc, sbox_tab[rk[15:8]], sbox_tab[rk[7:0]],
                 sbox_tab[rk[31:24]]};
            rk[127:96] = rk[127:96] ^ w;
            rk[95:64]  = rk[95:64] ^ rk[127:96];
            rk[63:32]  = rk[63:32] ^ rk[95:64];
            rk[31:0]   = rk[31:0] ^ rk[63:32];
            st = st ^ rk;
            rc = gmul(rc, 2);
        end
        return st;
    endfunction

    function automatic cipher_byte_t cipher_byte(input logic [7:0] data, input logic first,
                                                 input logic last, input logic [31:0] ssrc,
                                                 input logic [47:0] index);
        cipher_byte_t res;
        if (first) begin
            ctr_prefix = sess_salt ^ {32'h0, ssrc, index};
            blk_num = '0;
            byte_pos = '0;
        end
        if (byte_pos == 0) ks_blk = aes128(sess_key, {ctr_prefix, blk_num});
        res.data = data ^ ks_blk[127 - 8*byte_pos -: 8];
        res.last = last;
        byte_pos = byte_pos + 1'b1;
        if (byte_pos == 0) blk_num = blk_num + 1'b1;
        return res;
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic first, input logic last,
                             input logic [31:0] ssrc, input logic [47:0] index,
                             input logic typed, input logic [7:0] typed_out);
        bit           go;
        cipher_byte_t res;
        if (burst_left == 0) begin
            if (tx_gaps) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data_in <= data;
        s_first_of_packet <= first;
        s_last_of_packet <= last;
        s_ssrc <= ssrc;
        s_packet_index <= index;
        do begin
            @(negedge aclk);
            go = s_ready;
            @(posedge aclk);
        end while (!go);
        res = cipher_byte(data, first, last, ssrc, index);
        if (typed) res.data = typed_out;
        exp_bytes.push_back(res);
        items_sent++;
    endtask

    task automatic drain_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (exp_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        case (idx)
            REG_KEY_HIGH:  sess_key[127:64] = value;
            REG_KEY_LOW:   sess_key[63:0] = value;
            REG_SALT_HIGH: sess_salt[111:64] = value[47:0];
            REG_SALT_LOW:  sess_salt[63:0] = value;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [63:0] kh, input logic [63:0] kl,
                             input logic [63:0] sh, input logic [63:0] sl);
        write_reg(REG_KEY_HIGH, kh);
        write_reg(REG_KEY_LOW, kl);
        write_reg(REG_SALT_HIGH, sh);
        write_reg(REG_SALT_LOW, sl);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly well-formed packets, some loose bytes and broken marks
    task automatic send_traffic(input int count);
        int          len;
        int          kind;
        logic [31:0] ssrc;
        logic [47:0] index;
        while (count > 0) begin
            kind = $urandom_range(0, 9);
            ssrc = $urandom;
            index = 48'({$urandom, $urandom});
            if (kind < 8) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 60)
                                                  : $urandom_range(1, 20);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom), i == 0, i == len - 1, ssrc, index, 1'b0, 8'h00);
                count -= len;
            end else begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom), $urandom_range(0, 5) == 0,
                              $urandom_range(0, 3) == 0,
                              $urandom, 48'({$urandom, $urandom}), 1'b0, 8'h00);
                count -= len;
            end
        end
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        cipher_byte_t want;
        forever begin
            @(posedge aclk);
            if (rx_long) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                rx_long = 1'b0;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (rx_stalls && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 7);
            end
            @(negedge aclk);
            if (aresetn && m_valid === 1'b1 && m_ready) begin
                if (exp_bytes.size() == 0) begin
                    $display("%0t: unexpected item data_out=%h last_out=%b",
                             $time, m_data_out, m_last_out);
                    errors++;
                end else begin
                    want = exp_bytes.pop_front();
                    if (m_data_out !== want.data) begin
                        $display("%0t: data_out expected %h actual %h",
                                 $time, want.data, m_data_out);
                        errors++;
                    end
                    if (m_last_out !== want.last) begin
                        $display("%0t: last_out expected %b actual %b",
                                 $time, want.last, m_last_out);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        dir_row_t dir_tab[21];
        for (int i = 0; i < 256; i++) sbox_tab[i] = sbox_calc(i[7:0]);

        // zero key and zero counter block give keystream 66e94bd4ef8a2c3b884cfa59ca342b2e
        dir_tab[0]  = '{8'h00, 0, 0, 32'h0, 48'h0, 1, 8'h66};
        dir_tab[1]  = '{8'hFF, 0, 0, 32'h0, 48'h0, 1, 8'h16};
        dir_tab[2]  = '{8'h00, 0, 0, 32'h0, 48'h0, 1, 8'h4b};
        dir_tab[3]  = '{8'h00, 0, 0, 32'h0, 48'h0, 1, 8'hd4};
        dir_tab[4]  = '{8'h00, 0, 0, 32'h0, 48'h0, 1, 8'hef};
        dir_tab[5]  = '{8'h00, 0, 0, 32'h0, 48'h0, 1, 8'h8a};
        dir_tab[6]  = '{8'h00, 0, 0, 32'h0, 48'h0, 1, 8'h2c};
        dir_tab[7]  = '{8'h00, 0, 0, 32'h0, 48'h0, 1, 8'h3b};
        dir_tab[8]  = '{8'h00, 0, 0, 32'h0, 48'h0, 1, 8'h88};
        dir_tab[9]  = '{8'h00, 0, 0, 32'h0, 48'h0, 1, 8'h4c};
        dir_tab[10] = '{8'h00, 0, 0, 32'h0, 48'h0, 1, 8'hfa};
        dir_tab[11] = '{8'h00, 0, 0, 32'h0, 48'h0, 1, 8'h59};
        dir_tab[12] = '{8'h00, 0, 0, 32'h0, 48'h0, 1, 8'hca};
        dir_tab[13] = '{8'h00, 0, 0, 32'h0, 48'h0, 1, 8'h34};
        dir_tab[14] = '{8'h00, 0, 0, 32'h0, 48'h0, 1, 8'h2b};
        dir_tab[15] = '{8'h00, 0, 1, 32'h0, 48'h0, 1, 8'h2e};
        dir_tab[16] = '{8'h5A, 0, 1, 32'h0, 48'h0, 0, 8'h00};
        dir_tab[17] = '{8'h00, 1, 0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0, 8'h00};
        dir_tab[18] = '{8'hFF, 0, 1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0, 8'h00};
        dir_tab[19] = '{8'hFF, 1, 1, 32'h0, 48'h0, 1, 8'h99};
        dir_tab[20] = '{8'h3C, 1, 0, 32'hDEAD_BEEF, 48'h1234_5678_9ABC, 0, 8'h00};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i])
            send_byte(dir_tab[i].data, dir_tab[i].first, dir_tab[i].last, dir_tab[i].ssrc,
                      dir_tab[i].index, dir_tab[i].typed, dir_tab[i].typed_out);
        drain_idle();

        write_all('1, '1, '1, '1);
        send_traffic(150);
        drain_idle();

        // hold the receiver off while the sender keeps offering items
        write_all(rand64(), rand64(), rand64(), rand64());
        tx_gaps = 1'b0;
        rx_long = 1'b1;
        send_traffic(120);
        tx_gaps = 1'b1;
        drain_idle();

        rx_stalls = 1'b0;
        write_all(rand64(), rand64(), '0, '0);
        send_traffic(100);
        rx_stalls = 1'b1;
        drain_idle();

        write_all(rand64(), rand64(), rand64(), rand64());
        send_traffic(180);
        drain_idle();

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
